// ===== design/b64e_pkg.sv =====
// Shared types, constants and the base64 alphabet lookup for the stream encoder.
`default_nettype none

package b64e_pkg;

    localparam int unsigned B64E_FIFO_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_LOWER = 7'h61;
    localparam logic [6:0] CHAR_DIGIT = 7'h30;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;

    // One queued item: up to four output characters, the index of the final
    // one, and whether that final character closes the message.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } b64e_entry_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26)
            r = CHAR_UPPER + {1'b0, v};
        else if (v < 6'd52)
            r = CHAR_LOWER + {1'b0, v - 6'd26};
        else if (v < 6'd62)
            r = CHAR_DIGIT + {1'b0, v - 6'd52};
        else if (v == 6'd62)
            r = CHAR_PLUS;
        else
            r = CHAR_SLASH;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder.
// Streaming base64 encoder, standard alphabet with '=' padding. Bytes enter on
// byte_valid/byte_stall; end_of_message marks the final byte, after which any
// partial character is flushed with zero fill, one or two '=' follow as needed
// and the final character carries last_char. Characters leave one per cycle on
// char_valid/char_stall when not stalled. A byte is taken by the front end and
// queued; its first character then passes through the item register and the
// output register. The sustained rate is set by the single-character output
// port: a byte yields 1 to 4 characters (phase-dependent; 2 for the third byte
// of a group), 4 per 3 bytes over a long message. The queue depth (FIFO_DEPTH
// items) lets the front keep accepting while the output is stalled, until full.
`default_nettype none

module base64_stream_encoder #(
    parameter int unsigned FIFO_DEPTH = b64e_pkg::B64E_FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [6:0]      out_char,
    output logic            last_char
);
    import b64e_pkg::*;

    logic        push_valid, push_ready;
    b64e_entry_t push_data;
    logic        pop_valid, pop_ready;
    b64e_entry_t pop_data;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_valid),
        .in_byte    (data_byte),
        .in_eom     (end_of_message),
        .in_stall   (byte_stall),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (char_valid),
        .out_stall (char_stall),
        .out_chr   (out_char),
        .out_last  (last_char)
    );

endmodule

`default_nettype wire

// ===== design/b64e_front.sv =====
// Front end: accepts bytes, tracks the 3-byte group phase and builds character items.
`default_nettype none

module b64e_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_eom,
    output logic                       in_stall,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output b64e_pkg::b64e_entry_t      push_data
);
    import b64e_pkg::*;

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    b64e_entry_t entry;
    logic        accept;

    assign in_stall   = !push_ready;
    assign push_valid = in_valid;
    assign push_data  = entry;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        entry          = '0;
        entry.eom      = in_eom;
        phase_next     = PH0;
        left_next      = 4'd0;
        case (phase_reg)
            PH1:
            begin
                entry.chars[0] = sextet_char({left_reg[1:0], in_byte[7:4]});
                if (in_eom)
                begin
                    entry.chars[1] = sextet_char({in_byte[3:0], 2'b00});
                    entry.chars[2] = PAD_CHAR;
                    entry.last_idx = 2'd2;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                    phase_next     = PH2;
                    left_next      = in_byte[3:0];
                end
            end
            PH2:
            begin
                entry.chars[0] = sextet_char({left_reg, in_byte[7:6]});
                entry.chars[1] = sextet_char(in_byte[5:0]);
                entry.last_idx = 2'd1;
            end
            default:
            begin
                // unused phase code falls in here too and acts as phase 0
                entry.chars[0] = sextet_char(in_byte[7:2]);
                if (in_eom)
                begin
                    entry.chars[1] = sextet_char({in_byte[1:0], 4'b0000});
                    entry.chars[2] = PAD_CHAR;
                    entry.chars[3] = PAD_CHAR;
                    entry.last_idx = 2'd3;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                    phase_next     = PH1;
                    left_next      = {2'b00, in_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_fifo.sv =====
// Small item queue between the front end and the character sequencer.
`default_nettype none

module b64e_fifo #(
    parameter int unsigned DEPTH = b64e_pkg::B64E_FIFO_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire b64e_pkg::b64e_entry_t push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output b64e_pkg::b64e_entry_t      pop_data
);
    import b64e_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] PTR_ONE  = AW'(1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    b64e_entry_t   mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        if (push && !pop)
            cnt_next = cnt_reg + CNT_ONE;
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// Back end: steps through each queued item; one char per cycle unless stalled.
`default_nettype none

module b64e_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire b64e_pkg::b64e_entry_t pop_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [6:0]                 out_chr,
    output logic                       out_last
);
    import b64e_pkg::*;

    b64e_entry_t cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [6:0]  out_chr_reg;
    logic        out_last_reg;
    logic        adv, fin;

    // the output register frees up when empty or when its item is taken
    assign adv       = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign fin       = adv && (idx_reg == cur_reg.last_idx);
    assign pop_ready = !cur_valid_reg || fin;

    assign out_valid = out_valid_reg;
    assign out_chr   = out_chr_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_valid && pop_ready)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (fin)
                cur_valid_reg <= 1'b0;
            else if (adv)
                idx_reg <= idx_reg + 2'd1;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            cur_reg <= pop_data;
        if (adv)
        begin
            out_chr_reg  <= cur_reg.chars[idx_reg];
            out_last_reg <= cur_reg.eom && (idx_reg == cur_reg.last_idx);
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_checker.sv =====
// Port-level checker for the base64 encoder and its bind to the top level.
`default_nettype none

module b64e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       byte_stall,
    input wire logic       char_valid,
    input wire logic       char_stall,
    input wire logic [6:0] out_char,
    input wire logic       last_char
);
    import b64e_pkg::*;

    logic char_ok;
    logic char_take;

    assign char_take = char_valid && !char_stall;
    assign char_ok   = (out_char >= 7'h41 && out_char <= 7'h5A)
                    || (out_char >= 7'h61 && out_char <= 7'h7A)
                    || (out_char >= 7'h30 && out_char <= 7'h39)
                    || (out_char == CHAR_PLUS) || (out_char == CHAR_SLASH)
                    || (out_char == PAD_CHAR);

    // stalled output holds its character
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=>
            char_valid && $stable(out_char) && $stable(last_char))
        else $error("output item changed while stalled");

    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> char_ok)
        else $error("character outside the base64 alphabet");

    // the first pad of a pair is followed at once by the second, which ends the message
    a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
        char_take && (out_char == PAD_CHAR) && !last_char |=>
            char_valid && (out_char == PAD_CHAR) && last_char)
        else $error("lone pad not followed by a final pad");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({byte_stall, char_valid}))
        else $error("handshake signal unknown");

    a_data_known: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> !$isunknown({out_char, last_char}))
        else $error("output item unknown while valid");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_stall (byte_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last_char  (last_char)
);

`default_nettype wire

// ===== dv/base64_stream_checker.sv =====
// Scoreboard for the base64 encoder: predicts characters per byte and checks the char channel.
`timescale 1ns / 100ps

module base64_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       char_valid,
    input  logic       char_stall,
    input  logic [6:0] out_char,
    input  logic       last_char,
    output int         fail_count,
    output int         pending_chars
);

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_PLUS    = 7'h2B;
    localparam logic [6:0] ASCII_SLASH   = 7'h2F;

    typedef enum logic [1:0] {
        GRP_BYTE0,
        GRP_BYTE1,
        GRP_BYTE2
    } grp_phase_t;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } b64_char_t;

    b64_char_t  expected_chars[$];
    grp_phase_t phase;
    logic [3:0] carry_bits;

    initial
    begin
        fail_count    = 0;
        pending_chars = 0;
        phase         = GRP_BYTE0;
        carry_bits    = 4'h0;
    end

    function automatic logic [6:0] b64_symbol(input logic [5:0] s);
        logic [6:0] sym;
        if (s < 6'd26)
            sym = ASCII_UPPER_A + 7'(s);
        else if (s < 6'd52)
            sym = ASCII_LOWER_A + 7'(s - 6'd26);
        else if (s < 6'd62)
            sym = ASCII_ZERO + 7'(s - 6'd52);
        else if (s == 6'd62)
            sym = ASCII_PLUS;
        else
            sym = ASCII_SLASH;
        return sym;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    task automatic push_char(input logic [6:0] c, input logic l);
        expected_chars.push_back('{code: c, last: l});
    endtask

    // Emit every sextet as soon as its bits are known; carry the rest.
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        case (phase)
            GRP_BYTE1:
            begin
                push_char(b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0);
                if (eom)
                begin
                    push_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    phase      = GRP_BYTE0;
                    carry_bits = 4'h0;
                end
                else
                begin
                    phase      = GRP_BYTE2;
                    carry_bits = b[3:0];
                end
            end
            GRP_BYTE2:
            begin
                push_char(b64_symbol({carry_bits, b[7:6]}), 1'b0);
                push_char(b64_symbol(b[5:0]), eom);
                phase      = GRP_BYTE0;
                carry_bits = 4'h0;
            end
            default:
            begin
                push_char(b64_symbol(b[7:2]), 1'b0);
                if (eom)
                begin
                    push_char(b64_symbol({b[1:0], 4'h0}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    phase      = GRP_BYTE0;
                    carry_bits = 4'h0;
                end
                else
                begin
                    phase      = GRP_BYTE1;
                    carry_bits = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        b64_char_t want;
        if (!rst_n)
        begin
            phase      = GRP_BYTE0;
            carry_bits = 4'h0;
            expected_chars.delete();
        end
        else
        begin
            // Output first: a byte taken at this edge cannot show up yet.
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("char 0x%02h with nothing expected", out_char));
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.code)
                        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                                  out_char, want.code));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                                                  last_char, want.last, want.code));
                end
            end
            if (byte_valid && !byte_stall)
                encode_byte(data_byte, end_of_message);
        end
        pending_chars = expected_chars.size();
    end

endmodule

// ===== dv/tb_base64_stream_encoder.sv =====
// Top-level testbench for the base64 encoder: byte stimulus, char-side stalls, verdict.
`timescale 1ns / 100ps

module tb_base64_stream_encoder;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 350;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       byte_valid     = 1'b0;
    logic [7:0] data_byte      = 8'h00;
    logic       end_of_message = 1'b0;
    logic       char_stall     = 1'b0;
    wire        byte_stall;
    wire        char_valid;
    wire  [6:0] out_char;
    wire        last_char;

    int fail_count;
    int pending_chars;
    int cycle_count  = 0;
    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;
    bit hold_request = 1'b0;
    bit hold_served  = 1'b0;

    always #6 clk = ~clk;

    base64_stream_encoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    base64_stream_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .out_char       (out_char),
        .last_char      (last_char),
        .fail_count     (fail_count),
        .pending_chars  (pending_chars)
    );

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid     <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (byte_stall);
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Char side: random hold-off per item, one long hold-off on request.
    initial
    begin
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = ~rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                hold        = LONG_HOLD;
            end
            if (hold > 0)
            begin
                char_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            char_stall <= 1'b0;
            do
                @(posedge clk);
            while (!char_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int msg_len;
        int random_sent;
        random_sent = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-byte messages with all-zero and all-one bytes: double pad
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two bytes: single pad
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b1);
        // full group, no pad
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        // '+' and '/' sextets
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // digit sextets
        send_byte(8'hD7, 1'b0);
        send_byte(8'h6D, 1'b0);
        send_byte(8'hF8, 1'b1);
        // two groups back to back, extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                tx_burst = ~tx_burst;
            if (!hold_request && random_sent >= 100)
            begin
                // back-to-back bytes while the char side is held off
                hold_request = 1'b1;
                tx_burst     = 1'b1;
                msg_len      = 24;
            end
            else if ($urandom_range(0, 7) == 0)
                msg_len = $urandom_range(10, 40);
            else
                msg_len = $urandom_range(1, 9);
            send_message(msg_len);
            random_sent += msg_len;
        end
        byte_valid <= 1'b0;

        while (pending_chars != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_fifo.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
design/b64e_checker.sv
dv/base64_stream_checker.sv
dv/tb_base64_stream_encoder.sv
